[design/vrot_pkg.sv]
// Shared types, constants and arithmetic helpers for the vector rotation unit.
`default_nettype none
package vrot_pkg;

    localparam int CW           = 34;
    localparam int ATAN_ENTRIES = 30;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

    localparam logic [31:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000, 32'h00010000,
        32'h00008000, 32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
        32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080, 32'h00000040,
        32'h00000020, 32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_cord;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } t_side;

    function automatic logic signed [31:0] clip_s32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sh7FFFFFFF) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -66'sh80000000) begin
            res = -32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic over_s32(input logic signed [65:0] v);
        return (v > 66'sh7FFFFFFF) || (v < -66'sh80000000);
    endfunction

    function automatic logic signed [65:0] rnd_q(input logic signed [63:0] p,
                                                 input int unsigned fb);
        logic signed [65:0] s;
        s = 66'(p) + (66'sd1 <<< (fb - 1));
        return s >>> fb;
    endfunction

endpackage
`default_nettype wire

[design/vrot_in_if.sv]
// Input channel: vector, axis and angle with valid/ready.
`default_nettype none
interface vrot_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle_degrees;

    modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                    angle_degrees, input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                  angle_degrees, output ready);
endinterface
`default_nettype wire

[design/vrot_out_if.sv]
// Output channel: rotated vector and saturation flag with valid/ready.
`default_nettype none
interface vrot_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               saturated;

    modport source (output valid, rotated_x, rotated_y, rotated_z, saturated,
                    input ready);
    modport sink (input valid, rotated_x, rotated_y, rotated_z, saturated,
                  output ready);
endinterface
`default_nettype wire

[design/vrot_angle.sv]
// Half-angle reduction and degree-to-radian conversion, five stages.
`default_nettype none
module vrot_angle #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic [4:0]            i_en,
    input  wire logic signed [31:0]    i_angle,
    output vrot_pkg::t_cord            o_cord
);
    import vrot_pkg::*;

    localparam int    FB    = FRACTION_BITS;
    localparam int    TW    = 48;
    localparam longint FULL = longint'(360) << (FB + 1);
    localparam longint QUAR = longint'(90) << (FB + 1);
    localparam longint KOFF = ((longint'(1) << 31) + FULL - 1) / FULL;
    localparam longint OFF  = KOFF * FULL;
    localparam int    NSTEP = $clog2(2 * KOFF + 2);
    localparam int    NHI   = (NSTEP + 1) / 2;
    localparam int    RW    = FB + 11;
    localparam int    MW    = FB + 8;
    localparam int    PW    = MW + 27;
    localparam logic signed [RW-1:0] C_FULL = RW'(FULL);
    localparam logic signed [RW-1:0] C_HALF = RW'(FULL / 2);
    localparam logic signed [RW-1:0] C_QUAR = RW'(QUAR);

    logic [TW-1:0]      r_t1, n_t1, r_t2, n_t2;
    logic [MW-1:0]      r_mag, n_mag;
    logic               r_neg3, n_neg3, r_flip3, n_flip3;
    logic [PW-1:0]      r_prod;
    logic               r_neg4, r_flip4;
    t_cord              r_out, n_out;

    always_comb begin
        n_t1 = TW'(i_angle) + TW'(OFF);
        for (int k = NSTEP - 1; k >= NSTEP - NHI; k--) begin
            if (n_t1 >= (TW'(FULL) << k)) begin
                n_t1 = n_t1 - (TW'(FULL) << k);
            end
        end
    end

    always_comb begin
        n_t2 = r_t1;
        for (int k = NSTEP - NHI - 1; k >= 0; k--) begin
            if (n_t2 >= (TW'(FULL) << k)) begin
                n_t2 = n_t2 - (TW'(FULL) << k);
            end
        end
    end

    always_comb begin
        logic signed [RW-1:0] rs;
        rs = signed'(r_t2[RW-1:0]);
        n_flip3 = 1'b0;
        if (rs >= C_HALF) begin
            rs = rs - C_FULL;
        end
        if (rs > C_QUAR) begin
            rs = rs - (C_QUAR <<< 1);
            n_flip3 = 1'b1;
        end else if (rs < -C_QUAR) begin
            rs = rs + (C_QUAR <<< 1);
            n_flip3 = 1'b1;
        end
        n_neg3 = rs < 0;
        n_mag  = n_neg3 ? MW'(-rs) : MW'(rs);
    end

    always_comb begin
        logic [PW-1:0]        sum;
        logic [PW-1:0]        q;
        logic signed [CW-1:0] zpos;
        sum  = r_prod + (PW'(1) << (FB + 2));
        q    = sum >> (FB + 3);
        zpos = {3'b000, q[30:0]};
        n_out.x    = CORDIC_GAIN;
        n_out.y    = '0;
        n_out.z    = r_neg4 ? -zpos : zpos;
        n_out.flip = r_flip4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t1 <= n_t1;
        end
        if (i_en[1]) begin
            r_t2 <= n_t2;
        end
        if (i_en[2]) begin
            r_mag   <= n_mag;
            r_neg3  <= n_neg3;
            r_flip3 <= n_flip3;
        end
        if (i_en[3]) begin
            r_prod  <= PW'(r_mag) * PW'(DEG_TO_RAD_Q32);
            r_neg4  <= r_neg3;
            r_flip4 <= r_flip3;
        end
        if (i_en[4]) begin
            r_out <= n_out;
        end
    end

    assign o_cord = r_out;

endmodule
`default_nettype wire

[design/vrot_cordic_cell.sv]
// One rotation-mode CORDIC iteration with its own register.
`default_nettype none
module vrot_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  vrot_pkg::t_cord i_cord,
    output vrot_pkg::t_cord o_cord
);
    import vrot_pkg::*;

    localparam logic signed [CW-1:0] ATAN = CW'(ATAN_Q30[IDX]);

    t_cord r_cord, n_cord;

    always_comb begin
        n_cord.flip = i_cord.flip;
        if (i_cord.z >= 0) begin
            n_cord.x = i_cord.x - (i_cord.y >>> IDX);
            n_cord.y = i_cord.y + (i_cord.x >>> IDX);
            n_cord.z = i_cord.z - ATAN;
        end else begin
            n_cord.x = i_cord.x + (i_cord.y >>> IDX);
            n_cord.y = i_cord.y - (i_cord.x >>> IDX);
            n_cord.z = i_cord.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
        end
    end

    assign o_cord = r_cord;

endmodule
`default_nettype wire

[design/vrot_quat.sv]
// Quaternion build and the two Hamilton products, six stages ending in the output register.
`default_nettype none
module vrot_quat #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic [5:0]         i_en,
    input  vrot_pkg::t_cord         i_cord,
    input  vrot_pkg::t_side         i_side,
    output logic signed [31:0]      o_rotated_x,
    output logic signed [31:0]      o_rotated_y,
    output logic signed [31:0]      o_rotated_z,
    output logic                    o_saturated
);
    import vrot_pkg::*;

    localparam int FB = FRACTION_BITS;

    logic signed [CW-1:0] w_sn, w_cs;
    logic signed [65:0]   r_pa [3];
    logic signed [CW-1:0] r_w0;
    logic signed [31:0]   r_v1 [3], r_v2 [3];
    logic signed [31:0]   r_u2 [3], r_u3 [3], r_u4 [3];
    logic signed [31:0]   r_w2, r_w3, r_w4;
    logic                 r_s2, r_s3, r_s4, r_s5;
    logic signed [63:0]   r_m3 [12], r_m5 [12];
    logic signed [31:0]   r_p4 [4];
    logic signed [31:0]   r_rx, r_ry, r_rz;
    logic                 r_sat;
    logic signed [31:0]   n_u2 [3], n_w2, n_p4 [4], n_rx, n_ry, n_rz;
    logic                 n_s2, n_s4, n_sat;
    logic signed [CW:0]   w_w0r;

    assign w_sn  = i_cord.flip ? -i_cord.y : i_cord.y;
    assign w_cs  = i_cord.flip ? -i_cord.x : i_cord.x;
    assign w_w0r = ((CW + 1)'(w_cs) + ((CW + 1)'(1) <<< (29 - FB))) >>> (30 - FB);

    always_comb begin
        logic signed [65:0] t;
        n_s2 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            t       = (r_pa[k] + (66'sd1 <<< 29)) >>> 30;
            n_u2[k] = clip_s32(t);
            n_s2    = n_s2 | over_s32(t);
        end
        n_w2 = clip_s32(66'(r_w0));
        n_s2 = n_s2 | over_s32(66'(r_w0));
    end

    always_comb begin
        logic signed [65:0] m [12];
        logic signed [65:0] s [4];
        for (int k = 0; k < 12; k++) begin
            m[k] = rnd_q(r_m3[k], FB);
        end
        s[0] = -(m[0] + m[1] + m[2]);
        s[1] = m[3] + m[4] - m[5];
        s[2] = m[6] + m[7] - m[8];
        s[3] = m[9] + m[10] - m[11];
        n_s4 = r_s3;
        for (int k = 0; k < 4; k++) begin
            n_p4[k] = clip_s32(s[k]);
            n_s4    = n_s4 | over_s32(s[k]);
        end
    end

    always_comb begin
        logic signed [65:0] m [12];
        logic signed [65:0] sx, sy, sz;
        for (int k = 0; k < 12; k++) begin
            m[k] = rnd_q(r_m5[k], FB);
        end
        sx    = -m[0] + m[1] - m[2] + m[3];
        sy    = -m[4] + m[5] - m[6] + m[7];
        sz    = -m[8] + m[9] - m[10] + m[11];
        n_rx  = clip_s32(sx);
        n_ry  = clip_s32(sy);
        n_rz  = clip_s32(sz);
        n_sat = r_s5 | over_s32(sx) | over_s32(sy) | over_s32(sz);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pa[0] <= 66'(i_side.axis_x) * 66'(w_sn);
            r_pa[1] <= 66'(i_side.axis_y) * 66'(w_sn);
            r_pa[2] <= 66'(i_side.axis_z) * 66'(w_sn);
            r_w0    <= w_w0r[CW-1:0];
            r_v1[0] <= i_side.vec_x;
            r_v1[1] <= i_side.vec_y;
            r_v1[2] <= i_side.vec_z;
        end
        if (i_en[1]) begin
            r_u2 <= n_u2;
            r_w2 <= n_w2;
            r_s2 <= n_s2;
            r_v2 <= r_v1;
        end
        if (i_en[2]) begin
            r_m3[0]  <= 64'(r_u2[0]) * 64'(r_v2[0]);
            r_m3[1]  <= 64'(r_u2[1]) * 64'(r_v2[1]);
            r_m3[2]  <= 64'(r_u2[2]) * 64'(r_v2[2]);
            r_m3[3]  <= 64'(r_w2)    * 64'(r_v2[0]);
            r_m3[4]  <= 64'(r_u2[1]) * 64'(r_v2[2]);
            r_m3[5]  <= 64'(r_u2[2]) * 64'(r_v2[1]);
            r_m3[6]  <= 64'(r_w2)    * 64'(r_v2[1]);
            r_m3[7]  <= 64'(r_u2[2]) * 64'(r_v2[0]);
            r_m3[8]  <= 64'(r_u2[0]) * 64'(r_v2[2]);
            r_m3[9]  <= 64'(r_w2)    * 64'(r_v2[2]);
            r_m3[10] <= 64'(r_u2[0]) * 64'(r_v2[1]);
            r_m3[11] <= 64'(r_u2[1]) * 64'(r_v2[0]);
            r_u3 <= r_u2;
            r_w3 <= r_w2;
            r_s3 <= r_s2;
        end
        if (i_en[3]) begin
            r_p4 <= n_p4;
            r_u4 <= r_u3;
            r_w4 <= r_w3;
            r_s4 <= n_s4;
        end
        if (i_en[4]) begin
            r_m5[0]  <= 64'(r_p4[0]) * 64'(r_u4[0]);
            r_m5[1]  <= 64'(r_w4)    * 64'(r_p4[1]);
            r_m5[2]  <= 64'(r_p4[2]) * 64'(r_u4[2]);
            r_m5[3]  <= 64'(r_p4[3]) * 64'(r_u4[1]);
            r_m5[4]  <= 64'(r_p4[0]) * 64'(r_u4[1]);
            r_m5[5]  <= 64'(r_w4)    * 64'(r_p4[2]);
            r_m5[6]  <= 64'(r_p4[3]) * 64'(r_u4[0]);
            r_m5[7]  <= 64'(r_p4[1]) * 64'(r_u4[2]);
            r_m5[8]  <= 64'(r_p4[0]) * 64'(r_u4[2]);
            r_m5[9]  <= 64'(r_w4)    * 64'(r_p4[3]);
            r_m5[10] <= 64'(r_p4[1]) * 64'(r_u4[1]);
            r_m5[11] <= 64'(r_p4[2]) * 64'(r_u4[0]);
            r_s5 <= r_s4;
        end
        if (i_en[5]) begin
            r_rx  <= n_rx;
            r_ry  <= n_ry;
            r_rz  <= n_rz;
            r_sat <= n_sat;
        end
    end

    assign o_rotated_x = r_rx;
    assign o_rotated_y = r_ry;
    assign o_rotated_z = r_rz;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

[design/vector_rotate_axis_angle_unit.sv]
// Items pass the input register, angle stages, one CORDIC cell per iteration and the
// quaternion stages; throughput is one item per cycle while the output is ready.
// Each stage advances when it is empty or its successor advances, so bubbles close up
// and new items enter while a finished result waits at the output register.
// Reset clears the stage valid flags only; payload registers keep their contents.
`default_nettype none
module vector_rotate_axis_angle_unit #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 18
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    vrot_in_if.sink      i_in,
    vrot_out_if.source   o_out
);
    import vrot_pkg::*;

    localparam int N    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int LAST = N + 11;

    logic [LAST:0]      r_vld;
    logic [LAST+1:0]    w_en;
    logic signed [31:0] r_ang;
    t_side              r_side [0:N+5];
    t_cord              w_cord [0:N];

    assign w_en[LAST+1] = o_out.ready;
    for (genvar k = 0; k <= LAST; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ang            <= i_in.angle_degrees;
            r_side[0].vec_x  <= i_in.vec_x;
            r_side[0].vec_y  <= i_in.vec_y;
            r_side[0].vec_z  <= i_in.vec_z;
            r_side[0].axis_x <= i_in.axis_x;
            r_side[0].axis_y <= i_in.axis_y;
            r_side[0].axis_z <= i_in.axis_z;
        end
        for (int k = 1; k <= N + 5; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    vrot_angle #(.FRACTION_BITS(FRACTION_BITS)) u_angle (
        .i_clk   (i_clk),
        .i_en    (w_en[5:1]),
        .i_angle (r_ang),
        .o_cord  (w_cord[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        vrot_cordic_cell #(.IDX(k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en[6+k]),
            .i_cord (w_cord[k]),
            .o_cord (w_cord[k+1])
        );
    end

    vrot_quat #(.FRACTION_BITS(FRACTION_BITS)) u_quat (
        .i_clk       (i_clk),
        .i_en        (w_en[N+11:N+6]),
        .i_cord      (w_cord[N]),
        .i_side      (r_side[N+5]),
        .o_rotated_x (o_out.rotated_x),
        .o_rotated_y (o_out.rotated_y),
        .o_rotated_z (o_out.rotated_z),
        .o_saturated (o_out.saturated)
    );

    assign o_out.valid = r_vld[LAST];

endmodule
`default_nettype wire

[design/vrot_checker.sv]
// Port-level checks for the vector rotation unit and their bind.
`default_nettype none
module vrot_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_rx,
    input wire logic [31:0] i_ry,
    input wire logic [31:0] i_rz,
    input wire logic        i_sat
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        $stable(i_rx) && $stable(i_ry) && $stable(i_rz) && $stable(i_sat))
        else $error("stalled output item changed");

endmodule

bind vector_rotate_axis_angle_unit vrot_checker u_vrot_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rx        (o_out.rotated_x),
    .i_ry        (o_out.rotated_y),
    .i_rz        (o_out.rotated_z),
    .i_sat       (o_out.saturated)
);
`default_nettype wire

[sim/vector_rotate_axis_angle_unit_chk.sv]
// Checker for the vector rotation unit: predicts each rotated vector and compares results.
`timescale 1ns / 100ps
`default_nettype none
module vector_rotate_axis_angle_unit_chk #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 18
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vrot_in_if        i_in,
    vrot_out_if       i_out,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic               sat;
    } t_rotated;

    t_rotated rotated_q[$];
    int       fails;

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint round_q(longint v, int sh);
        return floor_shift(v + (longint'(1) <<< (sh - 1)), sh);
    endfunction

    function automatic longint clip(longint v, ref logic sat);
        if (v > longint'(32'sh7FFFFFFF)) begin
            sat = 1'b1;
            return longint'(32'sh7FFFFFFF);
        end
        if (v < -longint'(64'h80000000)) begin
            sat = 1'b1;
            return -longint'(64'h80000000);
        end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_q(a * b, FRACTION_BITS);
    endfunction

    function automatic void half_sin_cos(longint ang, output longint sn, output longint cs);
        longint full, quarter, r, z, x, y, dx, dy;
        longint unsigned mag, prod;
        logic flip;
        full = longint'(360) <<< (FRACTION_BITS + 1);
        quarter = longint'(90) <<< (FRACTION_BITS + 1);
        r = ang % full;
        flip = 1'b0;
        x = vrot_pkg::CORDIC_GAIN;
        y = 0;
        if (r < 0) r += full;
        if (r >= full / 2) r -= full;
        if (r > quarter) begin
            r -= 2 * quarter;
            flip = 1'b1;
        end else if (r < -quarter) begin
            r += 2 * quarter;
            flip = 1'b1;
        end
        mag = (r < 0) ? -r : r;
        prod = mag * longint'(vrot_pkg::DEG_TO_RAD_Q32);
        prod = (prod + (64'd1 << (FRACTION_BITS + 2))) >> (FRACTION_BITS + 3);
        z = (r < 0) ? -longint'(prod) : longint'(prod);
        for (int i = 0; i < CORDIC_STEPS && i < vrot_pkg::ATAN_ENTRIES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(vrot_pkg::ATAN_Q30[i]);
            end else begin
                x += dx; y -= dy; z += longint'(vrot_pkg::ATAN_Q30[i]);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic t_rotated rotate(longint vx, longint vy, longint vz, longint ax,
                                        longint ay, longint az, longint ang);
        t_rotated res;
        logic sat;
        longint sn, cs, ux, uy, uz, w, pw, px, py, pz;
        sat = 1'b0;
        half_sin_cos(ang, sn, cs);
        ux = clip(round_q(ax * sn, 30), sat);
        uy = clip(round_q(ay * sn, 30), sat);
        uz = clip(round_q(az * sn, 30), sat);
        w  = clip(round_q(cs, 30 - FRACTION_BITS), sat);
        pw = clip(-(qmul(ux, vx) + qmul(uy, vy) + qmul(uz, vz)), sat);
        px = clip(qmul(w, vx) + qmul(uy, vz) - qmul(uz, vy), sat);
        py = clip(qmul(w, vy) + qmul(uz, vx) - qmul(ux, vz), sat);
        pz = clip(qmul(w, vz) + qmul(ux, vy) - qmul(uy, vx), sat);
        res.rx = 32'(clip(-qmul(pw, ux) + qmul(w, px) - qmul(py, uz) + qmul(pz, uy), sat));
        res.ry = 32'(clip(-qmul(pw, uy) + qmul(w, py) - qmul(pz, ux) + qmul(px, uz), sat));
        res.rz = 32'(clip(-qmul(pw, uz) + qmul(w, pz) - qmul(px, uy) + qmul(py, ux), sat));
        res.sat = sat;
        return res;
    endfunction

    assign o_fail_count = fails;
    assign o_pending    = rotated_q.size();

    initial fails = 0;

    always @(posedge i_clk) begin
        t_rotated exp_r;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            rotated_q.push_back(rotate(i_in.vec_x, i_in.vec_y, i_in.vec_z, i_in.axis_x,
                                       i_in.axis_y, i_in.axis_z, i_in.angle_degrees));
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (rotated_q.size() == 0) begin
                $error("unexpected result item");
                fails++;
            end else begin
                exp_r = rotated_q.pop_front();
                if (i_out.rotated_x !== exp_r.rx) begin
                    $error("rotated_x expected %0d actual %0d", exp_r.rx, i_out.rotated_x);
                    fails++;
                end
                if (i_out.rotated_y !== exp_r.ry) begin
                    $error("rotated_y expected %0d actual %0d", exp_r.ry, i_out.rotated_y);
                    fails++;
                end
                if (i_out.rotated_z !== exp_r.rz) begin
                    $error("rotated_z expected %0d actual %0d", exp_r.rz, i_out.rotated_z);
                    fails++;
                end
                if (i_out.saturated !== exp_r.sat) begin
                    $error("saturated expected %0b actual %0b", exp_r.sat, i_out.saturated);
                    fails++;
                end
            end
        end
    end

endmodule
`default_nettype wire

[sim/vector_rotate_axis_angle_unit_tb.sv]
// Testbench top for the vector rotation unit: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
`default_nettype none
module vector_rotate_axis_angle_unit_tb;

    localparam int N_RANDOM  = 1400;
    localparam int MAX_CYCLE = 400000;
    localparam int LATENCY   = 30;

    logic i_clk;
    logic i_rst_n;
    logic hold_off;
    int   fail_count;
    int   pending;
    int   cycle;

    vrot_in_if  in_ch();
    vrot_out_if out_ch();

    vector_rotate_axis_angle_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    vector_rotate_axis_angle_unit_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
            3: return $urandom_range(0, 3) - 1;
            4, 5: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 32'(int'($urandom_range(0, 16)) * 45 - 360) << 16;
            1: return 32'(int'($urandom_range(0, 2000)) - 1000) << 16;
            default: return pick_word();
        endcase
    endfunction

    task automatic send(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [31:0] ax,
                        logic [31:0] ay, logic [31:0] az, logic [31:0] ang);
        in_ch.valid         <= 1'b1;
        in_ch.vec_x         <= vx;
        in_ch.vec_y         <= vy;
        in_ch.vec_z         <= vz;
        in_ch.axis_x        <= ax;
        in_ch.axis_y        <= ay;
        in_ch.axis_z        <= az;
        in_ch.angle_degrees <= ang;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic gap(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_random();
        send(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
             pick_angle());
    endtask

    initial begin
        int stall_mode;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else begin
                stall_mode = (cycle / 300) % 3;
                out_ch.ready <= (stall_mode == 0) ? 1'b1 :
                                (stall_mode == 1) ? ($urandom_range(0, 3) != 0) :
                                ($urandom_range(0, 1) == 1);
            end
            @(negedge i_clk);
        end
    end

    initial begin
        localparam logic [31:0] ONE = 32'h00010000;
        int burst;
        int waited;
        cycle               = 0;
        hold_off            = 1'b0;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.vec_x         = '0;
        in_ch.vec_y         = '0;
        in_ch.vec_z         = '0;
        in_ch.axis_x        = '0;
        in_ch.axis_y        = '0;
        in_ch.axis_z        = '0;
        in_ch.angle_degrees = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send(ONE, 0, 0, 0, 0, ONE, 90 << 16);
        send(ONE, ONE, ONE, ONE, 0, 0, 180 << 16);
        send(ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, -(90 << 16));
        send(ONE, ONE, ONE, 0, 0, 0, 60 << 16);
        send(ONE, 0, 0, 0, 0, ONE, 360 << 16);
        send(ONE, 0, 0, 0, 0, ONE, 270 << 16);
        send(ONE, 0, 0, 0, 0, ONE, 32'h7FFFFFFF);
        send(ONE, 0, 0, 0, 0, ONE, 32'h80000000);
        send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0);
        send(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        send(32'h7FFFFFFF, 32'h80000000, ONE, 32'h7FFFFFFF, 32'h80000000, ONE, 123 << 16);
        send(ONE, ONE, ONE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 90 << 16);
        send(ONE, ONE, ONE, 10 * ONE, 0, 0, 45 << 16);
        send(32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 32'hFFFFFFFF);
        send(5 * ONE, -7 * ONE, 3 * ONE, ONE, ONE, 0, 179 << 16);
        send(5 * ONE, -7 * ONE, 3 * ONE, ONE, ONE, 0, -(181 << 16));
        gap(1);

        while (pending > 0) @(negedge i_clk);
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (80) send_random();
        join
        gap(1);

        for (int n = 0; n < N_RANDOM;) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) send_random();
            gap($urandom_range(0, 3) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 3));
            if (n > N_RANDOM / 2 && n < N_RANDOM / 2 + 41) begin
                while (pending > 0) @(negedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;

        while (pending > 0) @(negedge i_clk);
        waited = 0;
        while (waited < 2 * LATENCY + 20) begin
            @(negedge i_clk);
            waited++;
        end
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire

[vector_rotate_axis_angle_unit.f]
design/vrot_pkg.sv
design/vrot_in_if.sv
design/vrot_out_if.sv
design/vrot_angle.sv
design/vrot_cordic_cell.sv
design/vrot_quat.sv
design/vector_rotate_axis_angle_unit.sv
design/vrot_checker.sv
sim/vector_rotate_axis_angle_unit_chk.sv
sim/vector_rotate_axis_angle_unit_tb.sv
